>>> src/midi_to_cv_byte_parser_assert.svh
// ----------------------------------------------------------------------------
// MIDI to CV byte parser assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_TO_CV_BYTE_PARSER_ASSERT_SVH
`define MIDI_TO_CV_BYTE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mcv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mcv assertion failed");

`endif

>>> src/mcv_pkg.sv
// ----------------------------------------------------------------------------
// MIDI to CV parser package
// Types and constant codes shared by the parser, the result buffer and the top.
// ----------------------------------------------------------------------------
package mcv_pkg;

	// Field widths.
	localparam int unsigned ChanW  = 4;
	localparam int unsigned DacChW = 3;
	localparam int unsigned DacValW = 13;
	localparam int unsigned GateW  = 2;

	// Status bytes that change the parse state.
	localparam logic [7:0] CMD_NONE     = 8'h00;
	localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
	localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
	localparam logic [7:0] CMD_POLY_PR  = 8'hA0;
	localparam logic [7:0] CMD_CTRL     = 8'hB0;
	localparam logic [7:0] CMD_PROG     = 8'hC0;
	localparam logic [7:0] CMD_CHAN_PR  = 8'hD0;
	localparam logic [7:0] CMD_WHEEL    = 8'hE0;
	localparam logic [7:0] CMD_SYSEX    = 8'hF0;
	localparam logic [7:0] CMD_QFRAME   = 8'hF1;
	localparam logic [7:0] CMD_SONG_POS = 8'hF2;
	localparam logic [7:0] CMD_SONG_SEL = 8'hF3;
	localparam logic [7:0] CMD_EOX      = 8'hF7;

	// Sysex header bytes that enter the data phase.
	localparam logic [6:0] SX_MFR_CODE = 7'h7D;
	localparam logic [6:0] SX_DEV_CODE = 7'h10;

	// Byte phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_DATA0     = 3'd1;
	localparam logic [2:0] PH_DATA1     = 3'd2;
	localparam logic [2:0] PH_SYSCOM    = 3'd3;
	localparam logic [2:0] PH_SX_ID     = 3'd4;
	localparam logic [2:0] PH_SX_MODEL  = 3'd5;
	localparam logic [2:0] PH_SX_DATA   = 3'd6;
	localparam logic [2:0] PH_SX_IGNORE = 3'd7;

	// Gate action codes.
	localparam logic [1:0] GATE_NONE = 2'd0;
	localparam logic [1:0] GATE_ON   = 2'd1;
	localparam logic [1:0] GATE_OFF  = 2'd2;

	// DAC slot within a voice.
	localparam logic [1:0] SLOT_PITCH = 2'd0;
	localparam logic [1:0] SLOT_VEL   = 2'd1;
	localparam logic [1:0] SLOT_PRESS = 2'd2;
	localparam logic [1:0] SLOT_WHEEL = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_VOICE1 = 1'b0;
	localparam logic CFG_VOICE2 = 1'b1;

	// One DAC update.
	typedef struct packed {
		logic [DacChW-1:0]  dac_channel;
		logic [DacValW-1:0] dac_value;
		logic [GateW-1:0]   gate_action;
		logic               last_of_run;
	} result_t;

	// Results caused by one byte, handed from the parser to the buffer.
	typedef struct packed {
		logic       push;
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

>>> src/mcv_parser.sv
// ----------------------------------------------------------------------------
// MIDI running status parser
// Registers the incoming byte, then decodes it against the running status
// and produces up to two DAC updates in a single pass.
// ----------------------------------------------------------------------------
module mcv_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           midi_byte,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [3:0]           cfg_data,
	input  logic                 buf_free,
	output mcv_pkg::result_pair_t pair
);
	import mcv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       accept;

	logic [ChanW-1:0] voice1_q, voice2_q;
	logic [7:0]       cmd_q, cmd_d;
	logic [ChanW-1:0] chan_q, chan_d;
	logic [2:0]       phase_q, phase_d;
	logic [6:0]       fdb_q, fdb_d;

	logic       hit1, routed;
	logic [6:0] data7;
	logic [1:0] count;
	result_t    r0, r1;

	// The input register is released when its results fit in the buffer.
	assign adv      = valid_s1 && ((count == 2'd0) || buf_free);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= midi_byte;
		end
	end

	// Voice channel configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice1_q <= 4'd0;
			voice2_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOICE1: voice1_q <= cfg_data;
				CFG_VOICE2: voice2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Voice 1 takes priority when both voices share a channel.
	assign hit1   = (chan_q == voice1_q);
	assign routed = hit1 || (chan_q == voice2_q);
	assign data7  = byte_s1[6:0];

	// Decode the byte against the running status.
	always_comb begin
		cmd_d   = cmd_q;
		chan_d  = chan_q;
		phase_d = phase_q;
		fdb_d   = fdb_q;
		count   = 2'd0;
		r0      = '0;
		r1      = '0;
		r0.dac_channel = {!hit1, SLOT_PITCH};
		r1.dac_channel = {!hit1, SLOT_VEL};
		r0.last_of_run = 1'b1;
		r1.last_of_run = 1'b1;

		if (byte_s1[7]) begin
			if (byte_s1[7:4] != 4'hF) begin
				cmd_d   = {byte_s1[7:4], 4'h0};
				chan_d  = byte_s1[3:0];
				phase_d = PH_DATA0;
			end else begin
				unique case (byte_s1)
					CMD_SYSEX: begin
						cmd_d   = CMD_SYSEX;
						phase_d = PH_SX_ID;
					end
					CMD_QFRAME, CMD_SONG_SEL: begin
						cmd_d   = byte_s1;
						phase_d = PH_SYSCOM;
					end
					CMD_SONG_POS: begin
						cmd_d   = CMD_SONG_POS;
						phase_d = PH_DATA0;
					end
					CMD_EOX: begin
						cmd_d   = CMD_EOX;
						phase_d = PH_IDLE;
					end
					default: ;
				endcase
			end
		end else begin
			unique case (cmd_q)
				CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PR, CMD_CTRL, CMD_WHEEL,
				CMD_SONG_POS: begin
					if (phase_q == PH_DATA0) begin
						fdb_d   = data7;
						phase_d = PH_DATA1;
					end else if (phase_q == PH_DATA1) begin
						phase_d = (cmd_q == CMD_SONG_POS) ? PH_IDLE : PH_DATA0;
						if (routed) begin
							// The second data byte completes a channel message.
							if (cmd_q == CMD_NOTE_OFF || cmd_q == CMD_NOTE_ON) begin
								count          = 2'd2;
								r0.dac_value   = {1'b0, fdb_q, 5'd0};
								r0.last_of_run = 1'b0;
								r0.gate_action = (cmd_q == CMD_NOTE_ON && data7 != 7'd0)
									? GATE_ON : GATE_OFF;
								r1.dac_value   = {1'b0, data7, 5'd0};
							end else if (cmd_q == CMD_POLY_PR) begin
								count          = 2'd1;
								r0.dac_channel = {!hit1, SLOT_PRESS};
								r0.dac_value   = {1'b0, data7, 5'd0};
							end else if (cmd_q == CMD_WHEEL) begin
								count          = 2'd1;
								r0.dac_channel = {!hit1, SLOT_WHEEL};
								r0.dac_value   = {data7, fdb_q[6:1]};
							end
						end
					end
				end
				CMD_PROG: phase_d = PH_DATA0;
				CMD_CHAN_PR: begin
					if (routed) begin
						count          = 2'd1;
						r0.dac_channel = {!hit1, SLOT_PRESS};
						r0.dac_value   = {1'b0, data7, 5'd0};
					end
				end
				CMD_SYSEX: begin
					if (phase_q == PH_SX_ID) begin
						phase_d = (data7 == SX_MFR_CODE) ? PH_SX_MODEL : PH_SX_IGNORE;
					end else if (phase_q == PH_SX_MODEL) begin
						phase_d = (data7 == SX_DEV_CODE) ? PH_SX_DATA : PH_SX_IGNORE;
					end
				end
				CMD_QFRAME, CMD_SONG_SEL: phase_d = PH_IDLE;
				default: ;
			endcase
		end
	end

	// Running status registers advance with each processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_NONE;
			chan_q  <= '0;
			phase_q <= PH_IDLE;
			fdb_q   <= '0;
		end else if (adv) begin
			cmd_q   <= cmd_d;
			chan_q  <= chan_d;
			phase_q <= phase_d;
			fdb_q   <= fdb_d;
		end
	end

	assign pair.push  = adv && (count != 2'd0);
	assign pair.count = count;
	assign pair.r0    = r0;
	assign pair.r1    = r1;

endmodule

>>> src/mcv_out_buf.sv
// ----------------------------------------------------------------------------
// MIDI to CV result buffer
// Holds the DAC updates of one byte and hands them out one per transaction.
// ----------------------------------------------------------------------------
module mcv_out_buf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mcv_pkg::result_pair_t    pair,
	output logic                     buf_free,
	output logic                     out_valid,
	input  logic                     out_stall,
	output mcv_pkg::result_t         res
);
	import mcv_pkg::*;

	result_t    r0_q, r1_q;
	logic       head_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	// Room for a new pair once the last held result leaves this cycle.
	assign buf_free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign res       = head_q ? r1_q : r0_q;

	// Count and head pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (pair.push) begin
			cnt_q  <= pair.count;
			head_q <= 1'b0;
		end else if (pop) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pair.push) begin
			r0_q <= pair.r0;
			r1_q <= pair.r1;
		end
	end

endmodule

>>> src/midi_to_cv_byte_parser.sv
// ----------------------------------------------------------------------------
// MIDI to CV byte parser
// Two-voice MIDI running status parser that emits DAC updates.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one raw MIDI byte per transaction (in_valid,
// in_stall, midi_byte). The output channel gives DAC updates (out_valid,
// out_stall, dac_channel, dac_value, gate_action, last_of_run); on a voice
// channel a note message gives two, pressure and pitch wheel one, everything
// else none. The voice channels are to be set through the write port
// (cfg_we, cfg_index, cfg_data) only while no byte is in flight; the block
// does not enforce this. The byte sits in an input register while it is
// decoded, and its updates then drain from a two-entry result buffer at one
// per cycle while the receiver does not stall. The buffer accepts the next
// pair in the cycle its last entry is taken.
// Reset clears the running status, the phase and the channels to voice 1 on
// channel 0, voice 2 on channel 1. When the receiver stalls, the held update
// stays put, and the input stalls once a pending byte has results to store.
// ----------------------------------------------------------------------------
module midi_to_cv_byte_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  midi_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mcv_pkg::DacChW-1:0]  dac_channel,
	output logic [mcv_pkg::DacValW-1:0] dac_value,
	output logic [mcv_pkg::GateW-1:0]   gate_action,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [3:0]                  cfg_data
);
	import mcv_pkg::*;

	result_pair_t pair;
	result_t      res;
	logic         buf_free;

	// Decode stage with running status.
	mcv_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.midi_byte(midi_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.buf_free (buf_free),
		.pair     (pair)
	);

	// Result buffer.
	mcv_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.buf_free (buf_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	assign dac_channel = res.dac_channel;
	assign dac_value   = res.dac_value;
	assign gate_action = res.gate_action;
	assign last_of_run = res.last_of_run;

endmodule

>>> src/mcv_checker.sv
// ----------------------------------------------------------------------------
// MIDI to CV parser port checker
// Checks what the top level's ports show over time.
// ----------------------------------------------------------------------------
`include "midi_to_cv_byte_parser_assert.svh"

module mcv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mcv_pkg::DacChW-1:0]  dac_channel,
	input logic [mcv_pkg::GateW-1:0]   gate_action,
	input logic                        last_of_run
);
	import mcv_pkg::*;

	// A stalled update stays offered.
	`MCV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// Only the defined gate codes appear.
	`MCV_ASSERT_IMPLY(a_gate_code, clk, arst_n, out_valid,
		(gate_action == GATE_NONE) || (gate_action == GATE_ON) || (gate_action == GATE_OFF))

	// The gate only moves with a pitch update.
	`MCV_ASSERT_IMPLY(a_gate_pitch, clk, arst_n, out_valid && gate_action != GATE_NONE,
		dac_channel[1:0] == SLOT_PITCH)

	// A pitch update is never the last of its run.
	`MCV_ASSERT_IMPLY(a_pitch_not_last, clk, arst_n,
		out_valid && dac_channel[1:0] == SLOT_PITCH, !last_of_run)

	// Velocity closes the run of a note byte.
	`MCV_ASSERT_IMPLY(a_vel_last, clk, arst_n,
		out_valid && dac_channel[1:0] == SLOT_VEL, last_of_run)

endmodule

bind midi_to_cv_byte_parser mcv_checker u_mcv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.dac_channel(dac_channel),
	.gate_action(gate_action),
	.last_of_run(last_of_run)
);

>>> bench/midi_to_cv_byte_parser_tb.sv
// ----------------------------------------------------------------------------
// MIDI to CV byte parser testbench
// Feeds raw MIDI bytes through the valid/stall input channel and compares
// every DAC update that leaves the output channel with a cycle-free model of
// the running status parser kept inside this bench. A short table of
// hand-picked bytes comes first, then random messages (mostly well formed,
// with truncated messages, stray data and noise mixed in) under several
// voice routings, with random idling on both sides and one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module midi_to_cv_byte_parser_tb;
	import mcv_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 4;
	localparam int DRAIN_CYCLES     = 8;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int HOLD_NOTES       = 20;
	localparam int PHASE_ITEMS      = 150;
	localparam int NUM_PHASES       = 7;
	localparam int DIRECTED_ROWS    = 28;
	localparam int MAX_PRINTED      = 30;

	// System bytes that the parser must leave alone.
	localparam logic [7:0] SYS_UNDEF_FIRST = 8'hF4;
	localparam logic [7:0] RT_TIMING_CLOCK = 8'hF8;

	localparam result_t NO_UPD = '0;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		logic [7:0] midi;
		logic       typed;
		logic [1:0] count;
		result_t    u0;
		result_t    u1;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          midi_byte;
	logic                out_valid;
	logic                out_stall;
	logic [DacChW-1:0]   dac_channel;
	logic [DacValW-1:0]  dac_value;
	logic [GateW-1:0]    gate_action;
	logic                last_of_run;
	logic                cfg_we;
	logic                cfg_index;
	logic [3:0]          cfg_data;

	// Parser state as the bench sees it.
	logic [7:0] run_cmd     = CMD_NONE;
	logic [3:0] run_chan    = 4'd0;
	logic [2:0] run_phase   = PH_IDLE;
	logic [6:0] held_data   = 7'd0;
	logic [3:0] voice1_chan = 4'd0;
	logic [3:0] voice2_chan = 4'd1;

	result_t dac_updates_due[$];

	int mismatches    = 0;
	int bytes_sent    = 0;
	int updates_seen  = 0;
	int quiet_cycles  = 0;
	bit sender_gaps   = 1'b1;
	bit receiver_idle = 1'b1;
	bit long_hold_req = 1'b0;

	midi_to_cv_byte_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.midi_byte   (midi_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dac_channel (dac_channel),
		.dac_value   (dac_value),
		.gate_action (gate_action),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Builds one DAC update from the voice, the slot within the voice and the payload.
	function automatic result_t mk_upd(input logic voice2, input logic [1:0] slot,
		input logic [12:0] value, input logic [1:0] gate, input logic last);
		return {voice2, slot, value, gate, last};
	endfunction

	// Steps a two-data-byte message; true when its second data byte has arrived.
	function automatic logic advance_pair(input logic [6:0] d);
		if (run_phase == PH_DATA0) begin
			held_data = d;
			run_phase = PH_DATA1;
			return 1'b0;
		end
		if (run_phase == PH_DATA1) begin
			run_phase = PH_DATA0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the parser state by one byte and works out the DAC updates it causes.
	task automatic predict_dac_updates(input logic [7:0] mb, output int n,
		output result_t u0, output result_t u1);
		logic        routed;
		logic        v2;
		logic        complete;
		logic [13:0] wheel14;
		n = 0;
		u0 = NO_UPD;
		u1 = NO_UPD;
		if (mb[7]) begin
			// Status bytes: channel messages restart the phase, system ones vary.
			if (mb < CMD_SYSEX) begin
				run_cmd = {mb[7:4], 4'h0};
				run_chan = mb[3:0];
				run_phase = PH_DATA0;
			end else begin
				case (mb)
					CMD_SYSEX: begin
						run_cmd = CMD_SYSEX;
						run_phase = PH_SX_ID;
					end
					CMD_QFRAME, CMD_SONG_SEL: begin
						run_cmd = mb;
						run_phase = PH_SYSCOM;
					end
					CMD_SONG_POS: begin
						run_cmd = CMD_SONG_POS;
						run_phase = PH_DATA0;
					end
					CMD_EOX: begin
						run_cmd = CMD_EOX;
						run_phase = PH_IDLE;
					end
					default: ;
				endcase
			end
		end else begin
			// Data bytes: voice 1 wins when both voices share a channel.
			routed = (run_chan == voice1_chan) || (run_chan == voice2_chan);
			v2 = (run_chan != voice1_chan);
			case (run_cmd)
				CMD_NOTE_OFF, CMD_NOTE_ON: begin
					complete = advance_pair(mb[6:0]);
					if (complete && routed) begin
						n = 2;
						u0 = mk_upd(v2, SLOT_PITCH, {1'b0, held_data, 5'b0},
							(run_cmd == CMD_NOTE_ON && mb[6:0] != 7'd0) ? GATE_ON : GATE_OFF,
							1'b0);
						u1 = mk_upd(v2, SLOT_VEL, {1'b0, mb[6:0], 5'b0}, GATE_NONE, 1'b1);
					end
				end
				CMD_POLY_PR: begin
					complete = advance_pair(mb[6:0]);
					if (complete && routed) begin
						n = 1;
						u0 = mk_upd(v2, SLOT_PRESS, {1'b0, mb[6:0], 5'b0}, GATE_NONE, 1'b1);
					end
				end
				CMD_CTRL: complete = advance_pair(mb[6:0]);
				CMD_PROG: run_phase = PH_DATA0;
				CMD_CHAN_PR: begin
					if (routed) begin
						n = 1;
						u0 = mk_upd(v2, SLOT_PRESS, {1'b0, mb[6:0], 5'b0}, GATE_NONE, 1'b1);
					end
				end
				CMD_WHEEL: begin
					complete = advance_pair(mb[6:0]);
					if (complete && routed) begin
						wheel14 = {mb[6:0], held_data};
						n = 1;
						u0 = mk_upd(v2, SLOT_WHEEL, wheel14[13:1], GATE_NONE, 1'b1);
					end
				end
				CMD_SYSEX: begin
					if (run_phase == PH_SX_ID)
						run_phase = (mb[6:0] == SX_MFR_CODE) ? PH_SX_MODEL : PH_SX_IGNORE;
					else if (run_phase == PH_SX_MODEL)
						run_phase = (mb[6:0] == SX_DEV_CODE) ? PH_SX_DATA : PH_SX_IGNORE;
				end
				CMD_QFRAME, CMD_SONG_SEL: run_phase = PH_IDLE;
				CMD_SONG_POS: begin
					if (run_phase == PH_DATA0) begin
						held_data = mb[6:0];
						run_phase = PH_DATA1;
					end else if (run_phase == PH_DATA1) begin
						run_phase = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	endtask

	function automatic stim_row_t plain(input logic [7:0] mb);
		return {mb, 1'b0, 2'd0, NO_UPD, NO_UPD};
	endfunction

	function automatic stim_row_t typed_row(input logic [7:0] mb, input logic [1:0] n,
		input result_t u0, input result_t u1);
		return {mb, 1'b1, n, u0, u1};
	endfunction

	// Directed table, run under the reset routing (voice 1 on 0, voice 2 on 1).
	function automatic stim_row_t directed_row(input int i);
		case (i)
			// Data byte before any status is dropped.
			0:  return typed_row(8'h40, 2'd0, NO_UPD, NO_UPD);
			1:  return plain(CMD_NOTE_ON);
			2:  return plain(8'h00);
			3:  return typed_row(8'h7F, 2'd2,
				mk_upd(1'b0, SLOT_PITCH, 13'd0, GATE_ON, 1'b0),
				mk_upd(1'b0, SLOT_VEL, 13'd4064, GATE_NONE, 1'b1));
			// Running status note on with velocity zero drops the gate.
			4:  return plain(8'h7F);
			5:  return typed_row(8'h00, 2'd2,
				mk_upd(1'b0, SLOT_PITCH, 13'd4064, GATE_OFF, 1'b0),
				mk_upd(1'b0, SLOT_VEL, 13'd0, GATE_NONE, 1'b1));
			6:  return plain(CMD_NOTE_OFF | 8'h01);
			7:  return plain(8'h3C);
			8:  return plain(8'h40);
			9:  return plain(CMD_POLY_PR);
			10: return plain(8'h10);
			11: return typed_row(8'h7F, 2'd1,
				mk_upd(1'b0, SLOT_PRESS, 13'd4064, GATE_NONE, 1'b1), NO_UPD);
			// A timing clock in the middle of a wheel message changes nothing.
			12: return plain(CMD_WHEEL);
			13: return plain(8'h7F);
			14: return typed_row(RT_TIMING_CLOCK, 2'd0, NO_UPD, NO_UPD);
			15: return typed_row(8'h7F, 2'd1,
				mk_upd(1'b0, SLOT_WHEEL, 13'd8191, GATE_NONE, 1'b1), NO_UPD);
			16: return plain(CMD_CHAN_PR | 8'h01);
			17: return plain(8'h55);
			18: return plain(CMD_CTRL);
			19: return plain(8'h07);
			20: return plain(8'h64);
			21: return plain(CMD_PROG | 8'h0F);
			22: return plain(8'h05);
			23: return plain(CMD_SYSEX);
			24: return plain({1'b0, SX_MFR_CODE});
			25: return plain({1'b0, SX_DEV_CODE});
			26: return plain(CMD_EOX);
			// Data after the end of a sysex has no command to belong to.
			27: return typed_row(8'h45, 2'd0, NO_UPD, NO_UPD);
			default: return plain(8'h00);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Offers one byte, predicts its updates on acceptance, then maybe idles.
	task automatic offer_byte(input logic [7:0] mb, input logic use_row, input stim_row_t row);
		int      n;
		result_t u0;
		result_t u1;
		in_valid <= 1'b1;
		midi_byte <= mb;
		do
			@(posedge clk);
		while (in_stall);
		predict_dac_updates(mb, n, u0, u1);
		if (use_row) begin
			n = row.count;
			u0 = row.u0;
			u1 = row.u1;
		end
		if (n >= 1)
			dac_updates_due.push_back(u0);
		if (n == 2)
			dac_updates_due.push_back(u1);
		bytes_sent++;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] mb);
		offer_byte(mb, 1'b0, '0);
	endtask

	function automatic logic [7:0] pick_ignored_sys();
		int r;
		r = $urandom_range(0, 8);
		if (r < 3)
			return SYS_UNDEF_FIRST + 8'(r);
		return RT_TIMING_CLOCK + 8'(r - 3);
	endfunction

	// Mostly the routed channels, sometimes any channel.
	function automatic logic [3:0] pick_channel();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return voice1_chan;
		if (r < 8)
			return voice2_chan;
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [6:0] rand_data();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 7'd0;
		if (r == 1)
			return 7'h7F;
		return 7'($urandom_range(0, 127));
	endfunction

	// Data byte, now and then preceded by a system byte that the parser ignores.
	task automatic send_data(input logic [6:0] d);
		if ($urandom_range(0, 19) == 0)
			send_byte(pick_ignored_sys());
		send_byte({1'b0, d});
	endtask

	// Status byte, left out now and then when running status allows it.
	task automatic send_status(input logic [7:0] cmd);
		if (run_cmd != cmd || $urandom_range(0, 3) != 0)
			send_byte(cmd | {4'h0, pick_channel()});
	endtask

	// Two-data-byte channel message, occasionally cut short.
	task automatic send_pair(input logic [7:0] cmd);
		send_status(cmd);
		send_data(rand_data());
		if ($urandom_range(0, 14) != 0)
			send_data(rand_data());
	endtask

	task automatic send_random_message();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			send_pair(CMD_NOTE_ON);
		end else if (r < 42) begin
			send_pair(CMD_NOTE_OFF);
		end else if (r < 50) begin
			send_pair(CMD_POLY_PR);
		end else if (r < 58) begin
			send_status(CMD_CHAN_PR);
			repeat ($urandom_range(1, 3)) send_data(rand_data());
		end else if (r < 68) begin
			send_pair(CMD_WHEEL);
		end else if (r < 73) begin
			send_pair(CMD_CTRL);
		end else if (r < 77) begin
			send_status(CMD_PROG);
			send_data(rand_data());
		end else if (r < 82) begin
			// System common message, sometimes followed by a stray data byte.
			k = $urandom_range(0, 2);
			if (k == 0) begin
				send_byte(CMD_QFRAME);
				send_data(rand_data());
			end else if (k == 1) begin
				send_byte(CMD_SONG_POS);
				send_data(rand_data());
				send_data(rand_data());
			end else begin
				send_byte(CMD_SONG_SEL);
				send_data(rand_data());
			end
			if ($urandom_range(0, 2) == 0)
				send_data(rand_data());
		end else if (r < 88) begin
			// Sysex with a matching or foreign header.
			send_byte(CMD_SYSEX);
			send_data(($urandom_range(0, 1) == 0) ? SX_MFR_CODE : rand_data());
			send_data(($urandom_range(0, 1) == 0) ? SX_DEV_CODE : rand_data());
			repeat ($urandom_range(0, 4)) send_data(rand_data());
			send_byte(CMD_EOX);
			if ($urandom_range(0, 2) == 0)
				send_data(rand_data());
		end else if (r < 95) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(pick_ignored_sys());
		end
	endtask

	// Register write, issued only once every expected update has drained.
	task automatic write_voice_cfg(input logic idx, input logic [3:0] val);
		while (dac_updates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_VOICE1)
			voice1_chan = val;
		else
			voice2_chan = val;
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 9);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Each output transaction is compared with the oldest expected update.
	always @(posedge clk) begin : check_updates
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {dac_channel, dac_value, gate_action, last_of_run};
			updates_seen++;
			if (dac_updates_due.size() == 0) begin
				report_mismatch($sformatf("unexpected update ch %0d value %0d gate %0d last %0b",
					got.dac_channel, got.dac_value, got.gate_action, got.last_of_run));
			end else begin
				want = dac_updates_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf(
						"got ch %0d value %0d gate %0d last %0b, want %0d %0d %0d %0b",
						got.dac_channel, got.dac_value, got.gate_action, got.last_of_run,
						want.dac_channel, want.dac_value, want.gate_action,
						want.last_of_run));
			end
		end
	end

	// Watchdog on cycles in which no transaction happens on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, then one random phase per routing.
	initial begin : stimulus
		int         i;
		int         p;
		int         target;
		logic [3:0] v1;
		logic [3:0] v2;
		stim_row_t  row;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		midi_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= CFG_VOICE1;
		cfg_data <= 4'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_row(i);
			offer_byte(row.midi, row.typed, row);
		end
		in_valid <= 1'b0;

		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin v1 = 4'd0;  v2 = 4'd1;  end
				1: begin v1 = 4'd15; v2 = 4'd0;  end
				2: begin v1 = 4'd6;  v2 = 4'd6;  end
				3: begin v1 = 4'd15; v2 = 4'd15; end
				4: begin v1 = 4'd0;  v2 = 4'd15; end
				default: begin
					v1 = 4'($urandom_range(0, 15));
					v2 = 4'($urandom_range(0, 15));
				end
			endcase
			write_voice_cfg(CFG_VOICE1, v1);
			write_voice_cfg(CFG_VOICE2, v2);
			// One phase runs without idling, and so does the last one.
			sender_gaps = (p != 3) && (p != NUM_PHASES - 1);
			receiver_idle = sender_gaps;
			if (p == 1) begin
				// Back-to-back notes while the receiver holds off.
				long_hold_req = 1'b1;
				sender_gaps = 1'b0;
				for (i = 0; i < HOLD_NOTES; i++)
					send_pair(CMD_NOTE_ON);
				sender_gaps = 1'b1;
			end
			target = bytes_sent + PHASE_ITEMS;
			while (bytes_sent < target)
				send_random_message();
			in_valid <= 1'b0;
		end

		while (dac_updates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d MIDI bytes (%0d from the directed table) over %0d routings.",
			bytes_sent, DIRECTED_ROWS, NUM_PHASES);
		$display("Checked %0d DAC updates, %0d mismatches.", updates_seen, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
